// ----- hdl/bb3f_pkg.sv -----
// ----------------------------------------------------------------------------
// Box blur frame unit package
// Shared widths, register indexes, item codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bb3f_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int DIM_W       = 10;
  localparam int COORD_W     = 9;
  localparam int CHAN_W      = 8;
  localparam int PIXEL_W     = 3 * CHAN_W;
  localparam int NUM_LANES   = 3;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int NUM_W       = 13;
  localparam int DEN_W       = 5;
  localparam int REM_W       = 5;
  localparam int DIV_STEPS   = 8;
  localparam int STEP_W      = 3;
  localparam int NB_W        = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 10'd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_RESULT
  } bb3f_state_t;

endpackage

// ----- hdl/box_blur_3x3_frame_unit.sv -----
// ----------------------------------------------------------------------------
// Box blur 3x3 frame unit
// RGB frame store with a write request and a 3x3 box-blurred read request.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Contents
// in_      slave      in_tvalid/in_tready  tdata: row, col, red, green, blue;
//                                          tuser: func
// out_     master     out_tvalid/out_tready tdata: red, green, blue;
//                                          tuser: range_error
// cfg_     write      cfg_we               cfg_index selects width or height
//
// Writes and out-of-frame requests go from the check step straight to the result
// step. Reads pass a check step, nine single-port store reads, a drain, a
// divider load, eight divider steps and a result step. A new request is taken
// only once the sequencer is back in idle.
// Reset clears the sequencer and sets both frame registers to 512, not the store.
// A waiting result blocks the sequencer in its result step until it is taken.
// ----------------------------------------------------------------------------
module box_blur_3x3_frame_unit #(
  parameter int MAX_WIDTH  = bb3f_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3f_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_row, pixel_col, red_in, green_in, blue_in, zero fill
  input  logic [bb3f_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // red_out, green_out, blue_out
  output logic [bb3f_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // range_error
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_we,
  input  logic [bb3f_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bb3f_pkg::DIM_W-1:0]         cfg_wdata
);
  import bb3f_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] WCAP = (MAX_WIDTH > 1023) ? 10'd1023 : DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HCAP = (MAX_HEIGHT > 1023) ? 10'd1023 : DIM_W'(MAX_HEIGHT);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [CHAN_W-1:0] nq;
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t cur, logic [DEN_W-1:0] den);
    logic [REM_W:0] trial;
    div_lane_t      nxt;
    trial  = {cur.rem, cur.nq[CHAN_W-1]};
    nxt.nq = {cur.nq[CHAN_W-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      nxt.rem   = REM_W'(trial - {1'b0, den});
      nxt.nq[0] = 1'b1;
    end else begin
      nxt.rem = REM_W'(trial);
    end
    return nxt;
  endfunction

  bb3f_state_t state_r, state_nxt;

  logic [DIM_W-1:0]   frame_width_r, frame_height_r;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic               func_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic [PIXEL_W-1:0] pix_r;
  logic               err_r, zero_r;
  logic [NB_W-1:0]    dr_r, dc_r;
  logic               pend_r;
  logic [SUM_W-1:0]   sum_r [NUM_LANES];
  logic [CNT_W-1:0]   cnt_r;
  div_lane_t          lane_r [NUM_LANES];
  logic [DEN_W-1:0]   den_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic               out_tuser_r;

  logic [PIXEL_W-1:0] frame_mem [DEPTH];
  logic [PIXEL_W-1:0] mem_rdata_r;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;

  logic               chk_err;
  logic [DIM_W-1:0]   nb_row, nb_col, addr_row, addr_col;
  logic               nb_ok;
  logic               nb_last;
  logic               out_free;
  logic               in_acc;
  logic               load_out;
  logic [NUM_W-1:0]   num [NUM_LANES];

  assign w_eff = (frame_width_r > WCAP) ? WCAP : frame_width_r;
  assign h_eff = (frame_height_r > HCAP) ? HCAP : frame_height_r;

  assign chk_err = ({1'b0, row_r} >= h_eff) || ({1'b0, col_r} >= w_eff);
  assign nb_row  = {1'b0, row_r} + DIM_W'(dr_r) - DIM_W'(1);
  assign nb_col  = {1'b0, col_r} + DIM_W'(dc_r) - DIM_W'(1);
  assign nb_last = (dr_r == NB_W'(2)) && (dc_r == NB_W'(2));
  assign out_free = !out_tvalid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      num[i] = NUM_W'({sum_r[i], 1'b0}) + NUM_W'(cnt_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = (chk_err || func_r == FUNC_WRITE) ? ST_RESULT : ST_FETCH;
      ST_FETCH:    if (nb_last) state_nxt = ST_DRAIN;
      ST_DRAIN:    state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV:      if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_RESULT;
      ST_RESULT:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    nb_ok     = 1'b0;
    load_out  = 1'b0;
    addr_row  = {1'b0, row_r};
    addr_col  = {1'b0, col_r};
    unique case (state_r)
      ST_IDLE:  in_tready = rst_n;
      ST_CHECK: mem_we = !chk_err && (func_r == FUNC_WRITE);
      ST_FETCH: begin
        addr_row = nb_row;
        addr_col = nb_col;
        nb_ok    = (nb_row < h_eff) && (nb_col < w_eff);
      end
      ST_RESULT: load_out = out_free;
      default: ;
    endcase
  end

  assign mem_addr = AW'(addr_row * MAX_WIDTH + addr_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= pix_r;
    end
    mem_rdata_r <= frame_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= DIM_RESET;
      frame_height_r <= DIM_RESET;
      out_tvalid_r   <= 1'b0;
      pend_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        endcase
      end
      pend_r <= nb_ok;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser[0];
      row_r  <= in_tdata[8:0];
      col_r  <= in_tdata[17:9];
      pix_r  <= {in_tdata[25:18], in_tdata[33:26], in_tdata[41:34]};
    end
    if (state_r == ST_CHECK) begin
      err_r  <= chk_err;
      zero_r <= chk_err || (func_r == FUNC_WRITE);
      dr_r   <= '0;
      dc_r   <= '0;
      cnt_r  <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      if (state_r == ST_FETCH) begin
        if (dc_r == NB_W'(2)) begin
          dc_r <= '0;
          dr_r <= dr_r + NB_W'(1);
        end else begin
          dc_r <= dc_r + NB_W'(1);
        end
      end
      if (pend_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        for (int i = 0; i < NUM_LANES; i++) begin
          sum_r[i] <= sum_r[i] +
                      SUM_W'(mem_rdata_r[PIXEL_W-1-i*CHAN_W -: CHAN_W]);
        end
      end
    end
    if (state_r == ST_DIV_LOAD) begin
      den_r  <= {cnt_r, 1'b0};
      step_r <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_r[i].rem <= num[i][NUM_W-1:CHAN_W];
        lane_r[i].nq  <= num[i][CHAN_W-1:0];
      end
    end else if (state_r == ST_DIV) begin
      step_r <= step_r + STEP_W'(1);
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_r[i] <= div_step(lane_r[i], den_r);
      end
    end
    if (load_out) begin
      out_tuser_r <= err_r;
      if (zero_r) begin
        out_tdata_r <= '0;
      end else begin
        out_tdata_r <= {lane_r[2].nq, lane_r[1].nq, lane_r[0].nq};
      end
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

// ----- hdl/bb3f_checker.sv -----
// ----------------------------------------------------------------------------
// Box blur frame unit checker
// Port-level checks on outstanding requests, result holding and error colour.
// ----------------------------------------------------------------------------
module bb3f_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bb3f_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                       out_tuser
);
  import bb3f_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == OUT_TDATA_W'(0))
    else $error("range error with non-zero colour");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while the previous one is still in work");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result shown with no request outstanding");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> pend_r <= 2'd1)
    else $error("too many requests outstanding");

endmodule

bind box_blur_3x3_frame_unit bb3f_checker u_bb3f_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box blur 3x3 frame unit testbench
// Writes pixels into the frame store and reads blurred pixels back under a
// series of frame sizes, from empty frames through saturated ones. Every
// request is predicted on acceptance by a scoreboard that keeps its own copy
// of the frame store, and each result is compared field by field in order.
// Reads only touch pixels whose neighbours have been written. Both stream
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import bb3f_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    logic              range_error;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } blur_result_t;

  class blur_scoreboard;
    bit [PIXEL_W-1:0] pixel_mem [STORE_DEPTH];
    int               frame_w;
    int               frame_h;
    blur_result_t     expected_q [$];
    int               fail_count;

    function new();
      frame_w    = MAX_WIDTH_DEF;
      frame_h    = MAX_HEIGHT_DEF;
      fail_count = 0;
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      if (idx == CFG_FRAME_WIDTH) begin
        frame_w = (value > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(value);
      end else begin
        frame_h = (value > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(value);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic func, logic [COORD_W-1:0] row,
                               logic [COORD_W-1:0] col, logic [CHAN_W-1:0] red,
                               logic [CHAN_W-1:0] green, logic [CHAN_W-1:0] blue);
      blur_result_t     res;
      int               sum_r, sum_g, sum_b, cnt, rr, cc;
      bit [PIXEL_W-1:0] px;
      res   = '0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt   = 0;
      if (row >= frame_h || col >= frame_w) begin
        res.range_error = 1'b1;
      end else if (func == FUNC_WRITE) begin
        pixel_mem[row * MAX_WIDTH_DEF + col] = {red, green, blue};
      end else begin
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = int'(row) + dr;
            cc = int'(col) + dc;
            if (rr >= 0 && rr < frame_h && cc >= 0 && cc < frame_w) begin
              px = pixel_mem[rr * MAX_WIDTH_DEF + cc];
              sum_r += int'(px[23:16]);
              sum_g += int'(px[15:8]);
              sum_b += int'(px[7:0]);
              cnt++;
            end
          end
        end
        res.red   = CHAN_W'((2 * sum_r + cnt) / (2 * cnt));
        res.green = CHAN_W'((2 * sum_g + cnt) / (2 * cnt));
        res.blue  = CHAN_W'((2 * sum_b + cnt) / (2 * cnt));
      end
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(blur_result_t got);
      blur_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("red expected %0d, got %0d", want.red, got.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green expected %0d, got %0d", want.green, got.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue expected %0d, got %0d", want.blue, got.blue));
        if (got.range_error !== want.range_error)
          report_mismatch($sformatf("range_error expected %0b, got %0b",
                                    want.range_error, got.range_error));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DIM_W-1:0]       cfg_wdata;

  blur_scoreboard sb;
  bit             written_map [STORE_DEPTH];
  int             gen_w;
  int             gen_h;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             items_sent;
  bit             pressure_phase;
  int             hold_left;
  bit             hold_done;

  box_blur_3x3_frame_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver owns its long hold-off and counts it down itself.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (pressure_phase && !hold_done && out_tvalid === 1'b1) begin
      hold_left  <= 400;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tuser[0], in_tdata[8:0], in_tdata[17:9], in_tdata[25:18],
                        in_tdata[33:26], in_tdata[41:34]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result({out_tuser[0], out_tdata[23:16], out_tdata[15:8],
                         out_tdata[7:0]});
      end
    end
  end

  function automatic bit in_frame(int row, int col);
    return row >= 0 && row < gen_h && col >= 0 && col < gen_w;
  endfunction

  function automatic bit neighbours_written(int row, int col);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (in_frame(row + dr, col + dc) &&
            !written_map[(row + dr) * MAX_WIDTH_DEF + col + dc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan(int mode);
    case (mode)
      1: return 8'hFF;
      2: return 8'h00;
      3: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  task automatic push_request(logic func, int row, int col, int mode);
    logic [CHAN_W-1:0] red, green, blue;
    red   = pick_chan(mode);
    green = pick_chan(mode);
    blue  = pick_chan(mode);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {6'b0, blue, green, red, col[COORD_W-1:0], row[COORD_W-1:0]};
    if (func == FUNC_WRITE && in_frame(row, col)) written_map[row * MAX_WIDTH_DEF + col] = 1'b1;
    items_sent++;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_patch(int row, int col, int mode);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (in_frame(row + dr, col + dc) &&
            (!written_map[(row + dr) * MAX_WIDTH_DEF + col + dc] || $urandom_range(3) == 0))
          push_request(FUNC_WRITE, row + dr, col + dc, mode);
      end
    end
  endtask

  task automatic configure(int width_val, int height_val, int idle_mode, bit pressure);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = width_val[DIM_W-1:0];
    sb.set_dim(CFG_FRAME_WIDTH, width_val[DIM_W-1:0]);
    @(negedge clk);
    cfg_index = CFG_FRAME_HEIGHT;
    cfg_wdata = height_val[DIM_W-1:0];
    sb.set_dim(CFG_FRAME_HEIGHT, height_val[DIM_W-1:0]);
    @(negedge clk);
    cfg_we         = 1'b0;
    gen_w          = (width_val > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_val;
    gen_h          = (height_val > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_val;
    send_idle_pct  = (idle_mode == 1) ? 78 : (idle_mode == 3) ? 35 : 0;
    recv_stall_pct = (idle_mode == 2) ? 78 : (idle_mode == 3) ? 35 : 0;
    pressure_phase = pressure;
  endtask

  function automatic int pick_coord(int dim);
    case ($urandom_range(9))
      0: return 0;
      1: return dim - 1;
      default: return $urandom_range(dim - 1);
    endcase
  endfunction

  task automatic blur_traffic();
    int  pick, row, col, rr, cc;
    logic func;
    pick = $urandom_range(99);
    if (pick < 20 && (gen_w < MAX_WIDTH_DEF || gen_h < MAX_HEIGHT_DEF) && gen_w > 0 &&
        gen_h > 0) begin
      // Coordinates just beyond or far beyond the frame.
      if (gen_h < MAX_HEIGHT_DEF && (gen_w >= MAX_WIDTH_DEF || $urandom_range(1))) begin
        row = $urandom_range(511, gen_h);
        col = $urandom_range(511);
      end else begin
        row = $urandom_range(511);
        col = $urandom_range(511, gen_w);
      end
      push_request(1'($urandom_range(1)), row, col, 0);
    end else if (pick < 32 || gen_w == 0 || gen_h == 0) begin
      row  = $urandom_range(511);
      col  = $urandom_range(511);
      func = 1'($urandom_range(1));
      if (func == FUNC_READ && in_frame(row, col) && !neighbours_written(row, col))
        func = FUNC_WRITE;
      push_request(func, row, col, 0);
    end else begin
      row = pick_coord(gen_h);
      col = pick_coord(gen_w);
      write_patch(row, col, $urandom_range(3));
      push_request(FUNC_READ, row, col, 0);
      if ($urandom_range(1)) begin
        rr = row + $urandom_range(2) - 1;
        cc = col + $urandom_range(2) - 1;
        if (in_frame(rr, cc) && neighbours_written(rr, cc))
          push_request(FUNC_READ, rr, cc, 0);
      end
      if ($urandom_range(9) < 3) begin
        push_request(FUNC_WRITE, row, col, 0);
        push_request(FUNC_READ, row, col, 0);
      end
    end
  endtask

  initial begin
    int phase_w    [11];
    int phase_h    [11];
    int phase_mode [11];
    int phase_cnt  [11];
    int target;
    phase_w        = '{1023, 7, 1, 2, 0, 512, 3, 16, 600, 0, 0};
    phase_h        = '{1023, 5, 1, 3, 9, 1, 512, 16, 0, 0, 0};
    phase_mode     = '{0, 1, 2, 3, 0, 1, 2, 0, 3, 3, 0};
    phase_cnt      = '{250, 250, 150, 200, 80, 150, 200, 250, 60, 200, 260};
    phase_w[9]     = $urandom_range(40, 1);
    phase_h[9]     = $urandom_range(40, 1);
    phase_w[10]    = $urandom_range(1023, 1);
    phase_h[10]    = $urandom_range(1023, 1);
    sb             = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = FUNC_WRITE;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FRAME_WIDTH;
    cfg_wdata      = '0;
    gen_w          = MAX_WIDTH_DEF;
    gen_h          = MAX_HEIGHT_DEF;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    pressure_phase = 1'b0;
    hold_left      = 0;
    hold_done      = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Corners, an edge and an interior pixel of the full-size frame.
    write_patch(0, 0, 1);
    push_request(FUNC_READ, 0, 0, 0);
    write_patch(511, 511, 2);
    push_request(FUNC_READ, 511, 511, 1);
    write_patch(5, 5, 3);
    push_request(FUNC_READ, 5, 5, 0);
    write_patch(0, 1, 0);
    push_request(FUNC_READ, 0, 1, 0);

    for (int p = 0; p < 11; p++) begin
      configure(phase_w[p], phase_h[p], phase_mode[p], p == 7);
      target = items_sent + phase_cnt[p];
      while (items_sent < target) blur_traffic();
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
